### src/clnw_pkg.sv
// ---------------------------------------------------------------------------
// clnw_pkg
// Shared types, constants and cursor helpers for the character display
// nibble writer.
// ---------------------------------------------------------------------------
package clnw_pkg;

  localparam int COLUMNS   = 20;
  localparam int ROWS      = 4;
  localparam int MAX_ERASE = 8;

  localparam int COL_W = $clog2(COLUMNS + 1);
  localparam int ROW_W = 2;
  localparam int CNT_W = $clog2(MAX_ERASE + 1);
  localparam int IDX_W = 4;
  localparam int BASE_W = 7;
  localparam int NUM_ROW_BASES = 4;
  localparam int INIT_LEN = 12;

  localparam int COL_MOD_STEPS = 31 / COLUMNS;
  localparam int ROW_MOD_STEPS = 3 / ROWS;

  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_BS    = 3'd1;
  localparam logic [2:0] CMD_CLEAR = 3'd2;
  localparam logic [2:0] CMD_MOVE  = 3'd3;
  localparam logic [2:0] CMD_RAW   = 3'd4;
  localparam logic [2:0] CMD_INIT  = 3'd5;

  localparam logic [1:0] WAIT_NONE  = 2'd0;
  localparam logic [1:0] WAIT_200US = 2'd1;
  localparam logic [1:0] WAIT_2MS   = 2'd2;
  localparam logic [1:0] WAIT_5MS   = 2'd3;

  localparam logic [7:0] INSTR_SET_DDRAM = 8'h80;
  localparam logic [7:0] INSTR_CLEAR     = 8'h01;
  localparam logic [7:0] INSTR_HOME      = 8'h02;
  localparam logic [7:0] CHAR_SPACE      = 8'h20;

  localparam logic [BASE_W-1:0] ROW_BASE_RESET [NUM_ROW_BASES] = '{
    7'd0, 7'd64, 7'd20, 7'd84
  };

  typedef struct packed {
    logic [3:0] nib;
    logic [1:0] wait_c;
  } init_nib_t;

  localparam init_nib_t INIT_SEQ [INIT_LEN] = '{
    '{4'h3, WAIT_5MS}, '{4'h3, WAIT_200US}, '{4'h3, WAIT_NONE}, '{4'h2, WAIT_NONE},
    '{4'h2, WAIT_NONE}, '{4'h8, WAIT_NONE}, '{4'h0, WAIT_NONE}, '{4'hC, WAIT_NONE},
    '{4'h0, WAIT_NONE}, '{4'h6, WAIT_NONE}, '{4'h0, WAIT_NONE}, '{4'h1, WAIT_2MS}
  };

  typedef enum logic [2:0] {
    JOB_PUT,
    JOB_BS,
    JOB_CLEAR,
    JOB_MOVE,
    JOB_RAW,
    JOB_INIT
  } job_kind_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic [4:0] column;
    logic [1:0] row;
    logic [3:0] erase_count;
  } request_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic       reg_select;
    logic [1:0] wait_code;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  typedef struct packed {
    job_kind_t        kind;
    logic [7:0]       data;
    pos_t             pos;
    logic [CNT_W-1:0] count;
    logic             wrap;
  } job_t;

  function automatic logic [ROW_W-1:0] inc_row(logic [ROW_W-1:0] r);
    return (r == ROW_W'(ROWS - 1)) ? '0 : r + ROW_W'(1);
  endfunction

  function automatic pos_t back_one(pos_t p);
    pos_t q;
    q = p;
    if (p.col == '0) begin
      q.col = COL_W'(COLUMNS - 1);
      q.row = (p.row == '0) ? ROW_W'(ROWS - 1) : p.row - ROW_W'(1);
    end else begin
      q.col = p.col - COL_W'(1);
    end
    return q;
  endfunction

  function automatic logic [COL_W-1:0] mod_cols(logic [4:0] c);
    logic [5:0] v;
    v = {1'b0, c};
    for (int k = 0; k < COL_MOD_STEPS; k++) begin
      if (v >= 6'(COLUMNS)) begin
        v = v - 6'(COLUMNS);
      end
    end
    return COL_W'(v);
  endfunction

  function automatic logic [ROW_W-1:0] mod_rows(logic [1:0] r);
    logic [2:0] v;
    v = {1'b0, r};
    for (int k = 0; k < ROW_MOD_STEPS; k++) begin
      if (v >= 3'(ROWS)) begin
        v = v - 3'(ROWS);
      end
    end
    return v[ROW_W-1:0];
  endfunction

endpackage

### src/char_lcd_cursor_nibble_writer.sv
// ---------------------------------------------------------------------------
// char_lcd_cursor_nibble_writer
// Turns display requests into 4-bit bus writes for a character display.
// ---------------------------------------------------------------------------
// A request is taken whenever the two-entry job queue has room, and the
// sequencer then sends one nibble per clock into a two-entry result queue
// while that queue has room: 2 nibbles for a raw instruction, a cursor
// move or a put without wrap, 4 for a clear or a put that wraps, 12 for
// init and 6 per erased character for a backspace, up to 48 for a
// backspace of eight characters. The job queue takes new requests while
// the sequencer still works on an earlier one. Requests with no output
// (unused codes, backspace by zero) are taken and produce nothing.
// Row base registers may be written only while the block is idle.
module char_lcd_cursor_nibble_writer import clnw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  request_t          request,
  output logic              empty,
  input  logic              pop,
  output result_t           result,
  input  logic              write_enable,
  input  logic [1:0]        write_index,
  input  logic [BASE_W-1:0] write_data
);

  logic accept;
  logic job_push;
  job_t job_new;
  logic q_full;
  logic q_valid;
  logic q_pop;
  job_t q_job;

  assign accept = push && !q_full;
  assign full   = q_full;

  clnw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .request  (request),
    .job_push (job_push),
    .job      (job_new)
  );

  clnw_job_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (job_new),
    .full    (q_full),
    .valid   (q_valid),
    .pop     (q_pop),
    .job_out (q_job)
  );

  clnw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .write_index  (write_index),
    .write_data   (write_data),
    .job_valid    (q_valid),
    .job_in       (q_job),
    .job_pop      (q_pop),
    .empty        (empty),
    .pop          (pop),
    .result       (result)
  );

endmodule

### src/clnw_front.sv
// ---------------------------------------------------------------------------
// clnw_front
// Accepts requests, tracks the cursor and turns each request into a job
// for the nibble sequencer.
// ---------------------------------------------------------------------------
module clnw_front import clnw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  request_t request,
  output logic     job_push,
  output job_t     job
);

  logic [COL_W-1:0] cursor_col;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col_next;
  logic [ROW_W-1:0] cursor_row_next;
  logic             job_valid;
  logic [CNT_W-1:0] cnt_sat;
  pos_t             cur;
  pos_t             walk;

  always_comb begin
    cur = '{row: cursor_row, col: cursor_col};
    cnt_sat = (request.erase_count > 4'(MAX_ERASE)) ? CNT_W'(MAX_ERASE)
                                                   : CNT_W'(request.erase_count);
    walk = cur;
    if (cursor_col >= COL_W'(cnt_sat)) begin
      walk.col = cursor_col - COL_W'(cnt_sat);
    end else begin
      walk.col = cursor_col + COL_W'(COLUMNS) - COL_W'(cnt_sat);
      walk.row = (cursor_row == '0) ? ROW_W'(ROWS - 1) : cursor_row - ROW_W'(1);
    end

    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    job_valid = 1'b0;
    job.kind = JOB_RAW;
    job.data = request.data_byte;
    job.pos = cur;
    job.count = cnt_sat;
    job.wrap = 1'b0;

    unique case (request.cmd)
      CMD_PUT: begin
        job_valid = 1'b1;
        job.kind = JOB_PUT;
        if (cursor_col >= COL_W'(COLUMNS)) begin
          job.wrap = 1'b1;
          job.pos = '{row: inc_row(cursor_row), col: '0};
          cursor_row_next = inc_row(cursor_row);
          cursor_col_next = COL_W'(1);
        end else begin
          cursor_col_next = cursor_col + COL_W'(1);
        end
      end
      CMD_BS: begin
        job_valid = (cnt_sat != '0);
        job.kind = JOB_BS;
        cursor_col_next = walk.col;
        cursor_row_next = walk.row;
      end
      CMD_CLEAR: begin
        job_valid = 1'b1;
        job.kind = JOB_CLEAR;
        job.pos = '0;
        cursor_col_next = '0;
        cursor_row_next = '0;
      end
      CMD_MOVE: begin
        job_valid = 1'b1;
        job.kind = JOB_MOVE;
        job.pos = '{row: mod_rows(request.row), col: mod_cols(request.column)};
        cursor_col_next = mod_cols(request.column);
        cursor_row_next = mod_rows(request.row);
      end
      CMD_RAW: begin
        job_valid = 1'b1;
        job.kind = JOB_RAW;
      end
      CMD_INIT: begin
        job_valid = 1'b1;
        job.kind = JOB_INIT;
      end
      default: begin
        job_valid = 1'b0;
      end
    endcase
  end

  assign job_push = accept && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (accept) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

endmodule

### src/clnw_job_queue.sv
// ---------------------------------------------------------------------------
// clnw_job_queue
// Two-entry job queue between the request front end and the sequencer.
// ---------------------------------------------------------------------------
module clnw_job_queue import clnw_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  output logic full,
  output logic valid,
  input  logic pop,
  output job_t job_out
);

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign job_out = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= job_in;
    end
  end

endmodule

### src/clnw_back.sv
// ---------------------------------------------------------------------------
// clnw_back
// Nibble sequencer: expands each job into bus nibbles, one per clock while
// its two-entry result queue has room, and holds the row base registers.
// ---------------------------------------------------------------------------
module clnw_back import clnw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              write_enable,
  input  logic [1:0]        write_index,
  input  logic [BASE_W-1:0] write_data,
  input  logic              job_valid,
  input  job_t              job_in,
  output logic              job_pop,
  output logic              empty,
  input  logic              pop,
  output result_t           result
);

  logic [BASE_W-1:0] row_base [NUM_ROW_BASES];

  logic             busy;
  job_t             job;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] steps_left;
  pos_t             pos;

  pos_t             addr_pos;
  logic [7:0]       addr;
  logic [7:0]       byte_val;
  logic             rs;
  logic [IDX_W-1:0] last_idx;
  logic             at_end;
  logic             finishing;
  logic             more_steps;
  logic             advance;
  logic             space;
  result_t          nib_item;

  result_t          oslots [2];
  logic             owptr;
  logic             orptr;
  logic [1:0]       ocount;
  logic             opop;

  always_comb begin
    unique case (job.kind)
      JOB_BS:    addr_pos = pos;
      JOB_CLEAR: addr_pos = '0;
      default:   addr_pos = job.pos;
    endcase
    addr = INSTR_SET_DDRAM | ({1'b0, row_base[addr_pos.row]} + 8'(addr_pos.col));

    byte_val = addr;
    rs = 1'b0;
    last_idx = IDX_W'(1);
    unique case (job.kind)
      JOB_PUT: begin
        last_idx = IDX_W'(3);
        if (idx >= IDX_W'(2)) begin
          byte_val = job.data;
          rs = 1'b1;
        end
      end
      JOB_BS: begin
        last_idx = IDX_W'(5);
        if (idx == IDX_W'(2) || idx == IDX_W'(3)) begin
          byte_val = CHAR_SPACE;
          rs = 1'b1;
        end
      end
      JOB_CLEAR: begin
        last_idx = IDX_W'(3);
        if (idx < IDX_W'(2)) begin
          byte_val = INSTR_CLEAR;
        end
      end
      JOB_MOVE: begin
        last_idx = IDX_W'(1);
      end
      JOB_RAW: begin
        byte_val = job.data;
      end
      JOB_INIT: begin
        last_idx = IDX_W'(INIT_LEN - 1);
      end
      default: begin
        last_idx = IDX_W'(1);
      end
    endcase

    if (job.kind == JOB_INIT) begin
      nib_item.nibble = INIT_SEQ[idx].nib;
      nib_item.wait_code = INIT_SEQ[idx].wait_c;
    end else begin
      nib_item.nibble = idx[0] ? byte_val[3:0] : byte_val[7:4];
      nib_item.wait_code = (idx[0] && !rs &&
                            (byte_val == INSTR_CLEAR || byte_val == INSTR_HOME))
                           ? WAIT_2MS : WAIT_NONE;
    end
    nib_item.reg_select = rs;

    at_end = (idx == last_idx);
    more_steps = (job.kind == JOB_BS) && (steps_left > CNT_W'(1));
    finishing = at_end && !more_steps;
    nib_item.last = finishing;
  end

  assign space   = (ocount != 2'd2);
  assign advance = busy && space;
  assign job_pop = job_valid && (!busy || (advance && finishing));
  assign opop    = pop && (ocount != 2'd0);
  assign empty   = (ocount == 2'd0);
  assign result  = oslots[orptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      owptr  <= 1'b0;
      orptr  <= 1'b0;
      ocount <= 2'd0;
      for (int i = 0; i < NUM_ROW_BASES; i++) begin
        row_base[i] <= ROW_BASE_RESET[i];
      end
    end else begin
      if (write_enable) begin
        row_base[write_index] <= write_data;
      end
      if (job_pop) begin
        busy <= 1'b1;
        job <= job_in;
        idx <= (job_in.kind == JOB_PUT && !job_in.wrap) ? IDX_W'(2) : '0;
        steps_left <= job_in.count;
        pos <= back_one(job_in.pos);
      end else if (advance) begin
        if (at_end) begin
          if (more_steps) begin
            steps_left <= steps_left - CNT_W'(1);
            pos <= back_one(pos);
            idx <= '0;
          end else begin
            busy <= 1'b0;
          end
        end else begin
          idx <= idx + IDX_W'(1);
        end
      end
      if (advance) begin
        owptr <= ~owptr;
      end
      if (opop) begin
        orptr <= ~orptr;
      end
      ocount <= ocount + 2'(advance) - 2'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      oslots[owptr] <= nib_item;
    end
  end

endmodule
